// ===== rtl/core/ybfc_pkg.sv =====
// Shared types, constants and the CRC-16 byte fold for the YMODEM block framer.
// No dependencies; every module of the framer imports this package.
package ybfc_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Byte positions within one framed item
  localparam logic [2:0] STEP_START = 3'd0;
  localparam logic [2:0] STEP_NUM   = 3'd1;
  localparam logic [2:0] STEP_CPL   = 3'd2;
  localparam logic [2:0] STEP_DATA  = 3'd3;
  localparam logic [2:0] STEP_CRCH  = 3'd4;
  localparam logic [2:0] STEP_CRCL  = 3'd5;

  // One classified item waiting for the serializer
  typedef struct packed {
    logic [7:0]  start_code;
    logic [7:0]  block_number;
    logic [7:0]  payload_byte;
    logic [15:0] crc;
    logic        first;
    logic        last;
  } entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Fold one byte into the CRC, MSB first
  function automatic logic [15:0] crc_fold(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/ybfc_front.sv =====
// Front end: accepts input beats, runs the block CRC and builds queue entries.
// Depends on ybfc_pkg.
module ybfc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_push,
  output logic            in_full,
  input  logic [7:0]      in_start_code,
  input  logic [7:0]      in_block_number,
  input  logic [7:0]      in_payload_byte,
  input  logic            in_first_of_block,
  input  logic            in_last_of_block,
  input  ybfc_pkg::q_stat_t q_stat,
  output logic            q_push,
  output ybfc_pkg::entry_t  q_entry
);
  import ybfc_pkg::*;

  logic [15:0] crc_r;
  logic [15:0] crc_nxt;
  logic [15:0] crc_base;

  assign in_full = q_stat.full;
  assign q_push  = in_push & ~q_stat.full;

  // Restart the CRC on the first byte of a block, then fold the byte in
  assign crc_base = in_first_of_block ? 16'h0000 : crc_r;
  assign crc_nxt  = crc_fold(crc_base, in_payload_byte);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= 16'h0000;
    end else if (q_push) begin
      crc_r <= crc_nxt;
    end
  end

  // Build the entry carried to the serializer
  always_comb begin
    q_entry.start_code   = in_start_code;
    q_entry.block_number = in_block_number;
    q_entry.payload_byte = in_payload_byte;
    q_entry.crc          = crc_nxt;
    q_entry.first        = in_first_of_block;
    q_entry.last         = in_last_of_block;
  end

endmodule

// ===== rtl/core/ybfc_queue.sv =====
// Short queue of classified entries between the front end and the serializer.
// Depends on ybfc_pkg.
module ybfc_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ybfc_pkg::entry_t  push_entry,
  input  logic              pop,
  output ybfc_pkg::entry_t  head,
  output ybfc_pkg::q_stat_t stat
);
  import ybfc_pkg::*;

  entry_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QCNT_W-1:0]   count_nxt;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign head       = slot_r[rd_ptr_r];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/core/ybfc_back.sv =====
// Back end: serializes the head entry into header, payload and CRC bytes.
// Depends on ybfc_pkg; holds the output register of the result channel.
module ybfc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  ybfc_pkg::entry_t  head,
  input  ybfc_pkg::q_stat_t q_stat,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_byte,
  output logic              out_frame_end
);
  import ybfc_pkg::*;

  logic [2:0] step_r;
  logic [2:0] step_nxt;
  logic [2:0] step_eff;
  logic       done;
  logic       load;
  logic [7:0] byte_sel;
  logic       end_sel;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_frame_end_r;

  // Skip the header when the entry does not open a block
  assign step_eff = (step_r == STEP_START && !head.first) ? STEP_DATA : step_r;
  assign done     = (step_eff == STEP_DATA && !head.last) || (step_eff == STEP_CRCL);

  assign load  = ~q_stat.empty & (~out_valid_r | out_pop);
  assign q_pop = load & done;

  // Pick the byte for the current position
  always_comb begin
    end_sel = 1'b0;
    case (step_eff)
      STEP_START: byte_sel = head.start_code;
      STEP_NUM:   byte_sel = head.block_number;
      STEP_CPL:   byte_sel = ~head.block_number;
      STEP_DATA:  byte_sel = head.payload_byte;
      STEP_CRCH:  byte_sel = head.crc[15:8];
      STEP_CRCL: begin
        byte_sel = head.crc[7:0];
        end_sel  = 1'b1;
      end
      default:    byte_sel = head.payload_byte;
    endcase
  end

  always_comb begin
    step_nxt = step_r;
    if (load) begin
      step_nxt = done ? STEP_START : step_eff + 3'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold position and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= STEP_START;
      out_valid_r <= 1'b0;
    end else begin
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the output beat
  always_ff @(posedge clk) begin
    if (load) begin
      out_byte_r      <= byte_sel;
      out_frame_end_r <= end_sel;
    end
  end

  assign out_empty     = ~out_valid_r;
  assign out_byte      = out_byte_r;
  assign out_frame_end = out_frame_end_r;

endmodule

// ===== rtl/core/ymodem_block_framer_crc16_unit.sv =====
// YMODEM block framer with CRC-16: top level; uses ybfc_front, ybfc_queue, ybfc_back.
// With the queue and output register empty, an accepted input beat is first written
// into the queue and then loaded as the first result byte into the output register.
// Throughput: one input beat per cycle while the 4-entry queue has room; the serializer
// moves one output beat per cycle while the queue holds an entry and the output register
// is empty or popped; an item yields 1 to 6 output bytes (header 3, payload 1, CRC 2).
// Synchronous active-low reset empties the queue and output register; CRC resets to 0.
module ymodem_block_framer_crc16_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_start_code,
  input  logic [7:0] in_block_number,
  input  logic [7:0] in_payload_byte,
  input  logic       in_first_of_block,
  input  logic       in_last_of_block,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_byte,
  output logic       out_frame_end
);
  import ybfc_pkg::*;

  q_stat_t q_stat;
  entry_t  q_entry;
  entry_t  q_head;
  logic    q_push;
  logic    q_pop;

  ybfc_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_start_code     (in_start_code),
    .in_block_number   (in_block_number),
    .in_payload_byte   (in_payload_byte),
    .in_first_of_block (in_first_of_block),
    .in_last_of_block  (in_last_of_block),
    .q_stat            (q_stat),
    .q_push            (q_push),
    .q_entry           (q_entry)
  );

  ybfc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  ybfc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (q_head),
    .q_stat        (q_stat),
    .q_pop         (q_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_byte      (out_byte),
    .out_frame_end (out_frame_end)
  );

  // Serializer never retires an entry from an empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // Front end never writes a full queue
  a_push_notfull: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue pushed while full");

  // An accepted beat is waiting in the queue on the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |=> !q_stat.empty)
    else $error("accepted beat lost from queue");

endmodule
